[src/swc_pkg.sv]
// Shared types and constants of the sliding window correlation block.
// No dependencies; used by swc_lane and sliding_window_correlation_top.
package swc_pkg;

  // Lane count and sample width are fixed by the frame ports
  localparam int LANES       = 3;
  localparam int SAMPLE_BITS = 16;
  localparam int CORR_BITS   = 16;
  localparam int FRAME_BITS  = 16;
  localparam int LEN_BITS    = 7;
  localparam int DIV_STEPS   = 16;

  localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd16;
  localparam logic                REG_WINDOW_LENGTH = 1'b0;

  // Control from the sequencer to every lane
  typedef struct packed {
    logic clear;
    logic update;
    logic sub;
    logic start;
  } lane_ctrl_t;

  // Status from a lane back to the sequencer
  typedef struct packed {
    logic busy;
  } lane_stat_t;

  typedef enum logic [3:0] {
    T_IDLE   = 4'b0001,
    T_READ   = 4'b0010,
    T_UPDATE = 4'b0100,
    T_CALC   = 4'b1000
  } top_state_t;

  typedef enum logic [6:0] {
    L_IDLE = 7'b0000001,
    L_PROD = 7'b0000010,
    L_VAR  = 7'b0000100,
    L_MUL  = 7'b0001000,
    L_SQRT = 7'b0010000,
    L_DIV  = 7'b0100000,
    L_FIN  = 7'b1000000
  } lane_state_t;

endpackage

[src/sliding_window_correlation_top.sv]
// Top level of the sliding window correlation block: APB register,
// frame history memory, sequencer, lanes and result merge. Uses swc_pkg, swc_lane.
//
//  channel  signals                          direction
//  config   psel penable pwrite paddr ...    APB write/read, pready tied high
//  frame    in_valid in_ready restart x y    input transfer
//  result   out_valid out_ready centre ...   output transfer
//
// A frame that does not fill the window gives no result.
// A frame with a full window gives a result once the bit-serial product, root
// and divide of every lane are done.
// One frame is in work at a time; a result waits in the output register, and
// a full output register holds the sequencer in its last step.
// Reset is synchronous; window, sums and frame count clear; window_length is 16.
module sliding_window_correlation_top #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [2:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   restart,
  input  logic signed [swc_pkg::SAMPLE_BITS-1:0] first_x0,
  input  logic signed [swc_pkg::SAMPLE_BITS-1:0] first_x1,
  input  logic signed [swc_pkg::SAMPLE_BITS-1:0] first_x2,
  input  logic signed [swc_pkg::SAMPLE_BITS-1:0] second_y0,
  input  logic signed [swc_pkg::SAMPLE_BITS-1:0] second_y1,
  input  logic signed [swc_pkg::SAMPLE_BITS-1:0] second_y2,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [swc_pkg::FRAME_BITS-1:0]         centre_frame,
  output logic signed [swc_pkg::CORR_BITS-1:0]   corr_lane0,
  output logic signed [swc_pkg::CORR_BITS-1:0]   corr_lane1,
  output logic signed [swc_pkg::CORR_BITS-1:0]   corr_lane2,
  output logic [swc_pkg::LANES-1:0]              degenerate_mask
);

  localparam int SW = swc_pkg::SAMPLE_BITS;
  localparam int NL = swc_pkg::LANES;
  localparam int LW = $clog2(MAX_WINDOW+1);
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DW = 2*NL*SW;
  localparam int FB = swc_pkg::FRAME_BITS;

  swc_pkg::top_state_t state;

  logic [swc_pkg::LEN_BITS-1:0] window_length;
  logic [LW-1:0]                len_eff, len_q;
  logic [LW-1:0]                fill;
  logic [AW-1:0]                wp;
  logic [FB-1:0]                frames_seen;
  logic [FB-1:0]                centre_q;
  logic [LW:0]                  old_sum;
  logic [AW-1:0]                old_addr;

  logic signed [SW-1:0] x_in [NL];
  logic signed [SW-1:0] y_in [NL];
  logic signed [SW-1:0] x_cap [NL];
  logic signed [SW-1:0] y_cap [NL];
  logic signed [SW-1:0] x_old [NL];
  logic signed [SW-1:0] y_old [NL];

  logic [DW-1:0] mem [MAX_WINDOW];
  logic [DW-1:0] mem_wdata, mem_rdata;

  swc_pkg::lane_ctrl_t lane_ctrl;
  swc_pkg::lane_stat_t lane_stat [NL];
  logic signed [swc_pkg::CORR_BITS-1:0] lane_corr [NL];
  logic [NL-1:0] lane_deg;

  logic cfg_wr, accept, full, full_after, load_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == swc_pkg::REG_WINDOW_LENGTH);
  assign prdata = (paddr[2] == swc_pkg::REG_WINDOW_LENGTH) ? 32'(window_length) : '0;

  // Hold the window length register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= swc_pkg::LEN_RESET;
    end else if (cfg_wr) begin
      window_length <= pwdata[swc_pkg::LEN_BITS-1:0];
    end
  end

  // Clamp the length to the supported range
  always_comb begin
    if (32'(window_length) > MAX_WINDOW) begin
      len_eff = LW'(MAX_WINDOW);
    end else if (window_length < 7'd2) begin
      len_eff = LW'(2);
    end else begin
      len_eff = LW'(window_length);
    end
  end

  assign x_in[0] = first_x0;
  assign x_in[1] = first_x1;
  assign x_in[2] = first_x2;
  assign y_in[0] = second_y0;
  assign y_in[1] = second_y1;
  assign y_in[2] = second_y2;

  assign in_ready   = (state == swc_pkg::T_IDLE);
  assign accept     = in_valid && in_ready;
  assign full       = (fill >= len_q);
  assign full_after = full || ((fill + 1'b1) >= len_q);
  assign load_out   = (state == swc_pkg::T_CALC) && !lane_stat[0].busy &&
                      (!out_valid || out_ready);

  // Leaving frame address: write pointer minus length, modulo depth
  always_comb begin
    old_sum = {1'b0, LW'(wp)} + (LW+1)'(MAX_WINDOW) - {1'b0, len_q};
    if (old_sum >= (LW+1)'(MAX_WINDOW)) begin
      old_sum = old_sum - (LW+1)'(MAX_WINDOW);
    end
    old_addr = AW'(old_sum);
  end

  // Pack and unpack history words
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      mem_wdata[i*SW +: SW]      = x_cap[i];
      mem_wdata[(NL+i)*SW +: SW] = y_cap[i];
      x_old[i] = mem_rdata[i*SW +: SW];
      y_old[i] = mem_rdata[(NL+i)*SW +: SW];
    end
  end

  // History memory: read the leaving frame, then write the new one
  always_ff @(posedge clk) begin
    if (state == swc_pkg::T_READ) begin
      mem_rdata <= mem[old_addr];
    end
    if (state == swc_pkg::T_UPDATE) begin
      mem[wp] <= mem_wdata;
    end
  end

  // Capture the frame on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      x_cap <= x_in;
      y_cap <= y_in;
      len_q <= len_eff;
    end
  end

  // Sequencer and window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= swc_pkg::T_IDLE;
      fill        <= '0;
      wp          <= '0;
      frames_seen <= '0;
    end else begin
      if (cfg_wr || (accept && restart)) begin
        fill        <= '0;
        wp          <= '0;
        frames_seen <= '0;
      end
      case (state)
        swc_pkg::T_IDLE: begin
          if (accept) begin
            state <= swc_pkg::T_READ;
          end
        end
        swc_pkg::T_READ: begin
          state <= swc_pkg::T_UPDATE;
        end
        swc_pkg::T_UPDATE: begin
          if (!full) begin
            fill <= fill + 1'b1;
          end
          wp          <= (wp == AW'(MAX_WINDOW-1)) ? '0 : wp + 1'b1;
          frames_seen <= frames_seen + 1'b1;
          centre_q    <= frames_seen - FB'(len_q) + FB'(1) + FB'(len_q >> 1);
          state       <= full_after ? swc_pkg::T_CALC : swc_pkg::T_IDLE;
        end
        swc_pkg::T_CALC: begin
          if (load_out) begin
            state <= swc_pkg::T_IDLE;
          end
        end
        default: begin
          state <= swc_pkg::T_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    lane_ctrl.clear  = cfg_wr || (accept && restart);
    lane_ctrl.update = (state == swc_pkg::T_UPDATE);
    lane_ctrl.sub    = full;
    lane_ctrl.start  = (state == swc_pkg::T_UPDATE) && full_after;
  end

  for (genvar g = 0; g < NL; g++) begin : g_lane
    swc_lane #(
      .MAX_WINDOW (MAX_WINDOW)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (lane_ctrl),
      .len   (len_q),
      .new_x (x_cap[g]),
      .new_y (y_cap[g]),
      .old_x (x_old[g]),
      .old_y (y_old[g]),
      .stat  (lane_stat[g]),
      .corr  (lane_corr[g]),
      .deg   (lane_deg[g])
    );
  end

  // Merge the lanes into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      centre_frame    <= centre_q;
      corr_lane0      <= lane_corr[0];
      corr_lane1      <= lane_corr[1];
      corr_lane2      <= lane_corr[2];
      degenerate_mask <= lane_deg;
    end
  end

endmodule

[src/swc_lane.sv]
// One correlation lane: running window sums and a bit-serial product,
// square root and divide. Depends on swc_pkg.
module swc_lane #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  swc_pkg::lane_ctrl_t                     ctrl,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]         len,
  input  logic signed [swc_pkg::SAMPLE_BITS-1:0]  new_x,
  input  logic signed [swc_pkg::SAMPLE_BITS-1:0]  new_y,
  input  logic signed [swc_pkg::SAMPLE_BITS-1:0]  old_x,
  input  logic signed [swc_pkg::SAMPLE_BITS-1:0]  old_y,
  output swc_pkg::lane_stat_t                     stat,
  output logic signed [swc_pkg::CORR_BITS-1:0]    corr,
  output logic                                    deg
);

  localparam int SW   = swc_pkg::SAMPLE_BITS;
  localparam int LW   = $clog2(MAX_WINDOW+1);
  localparam int AWM  = $clog2(MAX_WINDOW);
  localparam int SUMW = SW + AWM;
  localparam int SQW  = 2*SW + AWM;
  localparam int VW   = LW + SQW + 1;
  localparam int PW   = 2*VW;
  localparam int CW   = $clog2(VW+1);
  localparam int QW   = swc_pkg::DIV_STEPS;

  logic signed [SUMW-1:0] sx, sy;
  logic signed [SQW-1:0]  sxx, syy, sxy;

  logic signed [2*SW-1:0] nxx, nyy, nxy, oxx, oyy, oxy;

  swc_pkg::lane_state_t state;
  logic [CW-1:0]          cnt;

  logic signed [LW+SQW:0]   p_lxx, p_lyy, p_lxy;
  logic signed [2*SUMW-1:0] p_xx, p_yy, p_xy;
  logic signed [VW-1:0]     num;
  logic [VW-1:0]            mcand;
  logic [VW:0]              acc_hi;
  logic [VW-1:0]            acc_lo;
  logic [PW-1:0]            rad;
  logic [VW+2:0]            rem;
  logic [VW-1:0]            root;
  logic [VW:0]              r;
  logic [QW-1:0]            q;

  logic signed [VW-1:0] vx, vy, vnum;
  logic [VW:0]          add_hi;
  logic [VW+2:0]        rem_t, trial;
  logic [VW:0]          r_sh;
  logic [VW-1:0]        mag;
  logic [QW:0]          q_rnd;

  // New and leaving sample products
  assign nxx = new_x * new_x;
  assign nyy = new_y * new_y;
  assign nxy = new_x * new_y;
  assign oxx = old_x * old_x;
  assign oyy = old_y * old_y;
  assign oxy = old_x * old_y;

  // Hold the running sums; drop the leaving frame when the window is full
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sx  <= '0;
      sy  <= '0;
      sxx <= '0;
      syy <= '0;
      sxy <= '0;
    end else if (ctrl.update) begin
      if (ctrl.sub) begin
        sx  <= sx + SUMW'(new_x) - SUMW'(old_x);
        sy  <= sy + SUMW'(new_y) - SUMW'(old_y);
        sxx <= sxx + SQW'(nxx) - SQW'(oxx);
        syy <= syy + SQW'(nyy) - SQW'(oyy);
        sxy <= sxy + SQW'(nxy) - SQW'(oxy);
      end else begin
        sx  <= sx + SUMW'(new_x);
        sy  <= sy + SUMW'(new_y);
        sxx <= sxx + SQW'(nxx);
        syy <= syy + SQW'(nyy);
        sxy <= sxy + SQW'(nxy);
      end
    end
  end

  // Iteration datapath
  always_comb begin
    vx     = VW'(p_lxx) - VW'(p_xx);
    vy     = VW'(p_lyy) - VW'(p_yy);
    vnum   = VW'(p_lxy) - VW'(p_xy);
    add_hi = acc_lo[0] ? (acc_hi + {1'b0, mcand}) : acc_hi;
    rem_t  = {rem[VW:0], rad[PW-1:PW-2]};
    trial  = {1'b0, root, 2'b01};
    r_sh   = {r[VW-1:0], 1'b0};
    mag    = num[VW-1] ? VW'(-num) : VW'(num);
    if (mag > root) begin
      mag = root;
    end
    q_rnd  = ({1'b0, q} + 1'b1) >> 1;
  end

  // Sequence one correlation: products, variances, Vx*Vy, sqrt, divide
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swc_pkg::L_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        swc_pkg::L_IDLE: begin
          if (ctrl.start) begin
            state <= swc_pkg::L_PROD;
          end
        end
        swc_pkg::L_PROD: begin
          state <= swc_pkg::L_VAR;
        end
        swc_pkg::L_VAR: begin
          state <= swc_pkg::L_MUL;
          cnt   <= '0;
        end
        swc_pkg::L_MUL: begin
          if (cnt == CW'(VW-1)) begin
            state <= swc_pkg::L_SQRT;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        swc_pkg::L_SQRT: begin
          if (cnt == CW'(VW-1)) begin
            state <= swc_pkg::L_DIV;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        swc_pkg::L_DIV: begin
          if (cnt == CW'(QW-1)) begin
            state <= swc_pkg::L_FIN;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        swc_pkg::L_FIN: begin
          state <= swc_pkg::L_IDLE;
        end
        default: begin
          state <= swc_pkg::L_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      swc_pkg::L_PROD: begin
        p_lxx <= $signed({1'b0, len}) * sxx;
        p_lyy <= $signed({1'b0, len}) * syy;
        p_lxy <= $signed({1'b0, len}) * sxy;
        p_xx  <= sx * sx;
        p_yy  <= sy * sy;
        p_xy  <= sx * sy;
      end
      swc_pkg::L_VAR: begin
        num    <= vnum;
        deg    <= (vx <= 0) || (vy <= 0);
        mcand  <= vx;
        acc_hi <= '0;
        acc_lo <= vy;
      end
      swc_pkg::L_MUL: begin
        // shift-add, one multiplier bit a cycle
        {acc_hi, acc_lo} <= {add_hi, acc_lo} >> 1;
        if (cnt == CW'(VW-1)) begin
          rad  <= PW'({add_hi, acc_lo} >> 1);
          rem  <= '0;
          root <= '0;
        end
      end
      swc_pkg::L_SQRT: begin
        // one root bit a cycle
        rad <= {rad[PW-3:0], 2'b00};
        if (rem_t >= trial) begin
          rem  <= rem_t - trial;
          root <= {root[VW-2:0], 1'b1};
        end else begin
          rem  <= rem_t;
          root <= {root[VW-2:0], 1'b0};
        end
        if (cnt == CW'(VW-1)) begin
          r <= '0;
          q <= '0;
        end
      end
      swc_pkg::L_DIV: begin
        if (cnt == '0) begin
          if ({mag, 1'b0} >= {1'b0, root}) begin
            r <= {mag, 1'b0} - {1'b0, root};
            q <= {q[QW-2:0], 1'b1};
          end else begin
            r <= {mag, 1'b0};
            q <= {q[QW-2:0], 1'b0};
          end
        end else if (r_sh >= {1'b0, root}) begin
          r <= r_sh - {1'b0, root};
          q <= {q[QW-2:0], 1'b1};
        end else begin
          r <= r_sh;
          q <= {q[QW-2:0], 1'b0};
        end
      end
      swc_pkg::L_FIN: begin
        if (deg) begin
          corr <= '0;
        end else if (num[VW-1]) begin
          corr <= (q_rnd > (QW+1)'(32768)) ? 16'sh8000 : 16'(-q_rnd);
        end else begin
          corr <= (q_rnd > (QW+1)'(32767)) ? 16'sh7FFF : 16'(q_rnd);
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.busy = (state != swc_pkg::L_IDLE);

endmodule
